[rtl/eul_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_pkg
// Widths, types, angle table and clamp helpers for the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package eul_pkg;

  localparam int QW           = 16;
  localparam int PROD_W       = 32;
  localparam int ARG_W        = 34;
  localparam int VEC_W        = 36;
  localparam int ANG_W        = 24;
  localparam int RND_W        = 17;
  localparam int RND_SHIFT    = 7;
  localparam int CORDIC_STEPS = 21;
  localparam int SQRT_STEPS   = 31;
  localparam int ROOT_W       = 31;
  localparam int REM_W        = 33;
  localparam int RAD_W        = 62;
  localparam int MAG_W        = 30;
  localparam int SQ_W         = 60;
  localparam int DLY_LEN      = SQRT_STEPS + 2;
  localparam int TAG_LEN      = CORDIC_STEPS + 1;
  localparam int PIPE_DEPTH   = 4 + SQRT_STEPS + CORDIC_STEPS + 2;

  localparam logic signed [ANG_W-1:0] PI_WIDE   = ANG_W'(3294199);
  localparam logic signed [ANG_W-1:0] RND_BIAS  = ANG_W'(64);
  localparam logic signed [ARG_W-1:0] ONE_Q30   = ARG_W'(1073741824);
  localparam logic signed [RND_W-1:0] PI_Q13      = RND_W'(25736);
  localparam logic signed [RND_W-1:0] HALF_PI_Q13 = RND_W'(12868);

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] ang;
    logic                    zero;
  } eul_vec_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } eul_sqrt_t;

  typedef struct packed {
    logic signed [ARG_W-1:0] roll_a;
    logic signed [ARG_W-1:0] roll_b;
    logic signed [ARG_W-1:0] yaw_a;
    logic signed [ARG_W-1:0] yaw_b;
    logic signed [ARG_W-1:0] sin_p;
    logic                    sat;
  } eul_args_t;

  typedef struct packed {
    logic sat;
    logic neg;
  } eul_tag_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:       v = ANG_W'(823550);
      1:       v = ANG_W'(486170);
      2:       v = ANG_W'(256879);
      3:       v = ANG_W'(130396);
      4:       v = ANG_W'(65451);
      5:       v = ANG_W'(32757);
      6:       v = ANG_W'(16383);
      7:       v = ANG_W'(8192);
      8:       v = ANG_W'(4096);
      9:       v = ANG_W'(2048);
      10:      v = ANG_W'(1024);
      11:      v = ANG_W'(512);
      12:      v = ANG_W'(256);
      13:      v = ANG_W'(128);
      14:      v = ANG_W'(64);
      15:      v = ANG_W'(32);
      16:      v = ANG_W'(16);
      17:      v = ANG_W'(8);
      18:      v = ANG_W'(4);
      19:      v = ANG_W'(2);
      20:      v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [RND_W-1:0] clamp_ang(
    input logic signed [RND_W-1:0] v,
    input logic signed [RND_W-1:0] lim
  );
    logic signed [RND_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/eul_quat_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_quat_if
// Quaternion beat channel: valid, ready and four Q1.15 components.
// ----------------------------------------------------------------------------
interface eul_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

[rtl/eul_angle_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_angle_if
// Euler angle beat channel: valid, ready, Q3.13 roll and yaw, Q2.13 pitch and a flag.
// ----------------------------------------------------------------------------
interface eul_angle_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_saturated;

  modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
               output ready);
endinterface

[rtl/eul_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_sqrt_cell
// One digit of a restoring integer square root: takes two radicand bits,
// yields one root bit, hands the partial state to the next cell.
// ----------------------------------------------------------------------------
module eul_sqrt_cell
  import eul_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  eul_sqrt_t sq_i,
  output eul_sqrt_t sq_o
);

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  eul_sqrt_t        sq_nxt;
  eul_sqrt_t        sq_r;

  always_comb begin
    rem_sh = {sq_i.rem, sq_i.rad[RAD_W-1 -: 2]};
    trial  = {2'b00, sq_i.root, 2'b01};
    diff   = rem_sh - trial;
    sq_nxt.rad = {sq_i.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_nxt.rem  = diff[REM_W-1:0];
      sq_nxt.root = {sq_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = rem_sh[REM_W-1:0];
      sq_nxt.root = {sq_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule

[rtl/eul_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_cordic_cell
// One vectoring rotation step: rotate toward the x axis by atan(2^-STEP)
// and accumulate the angle.
// ----------------------------------------------------------------------------
module eul_cordic_cell
  import eul_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic     clk,
  input  logic     en,
  input  eul_vec_t vec_i,
  output eul_vec_t vec_o
);

  logic signed [VEC_W-1:0] xi;
  logic signed [VEC_W-1:0] yi;
  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;
  eul_vec_t                vec_nxt;
  eul_vec_t                vec_r;

  always_comb begin
    xi      = vec_i.x;
    yi      = vec_i.y;
    dx      = yi >>> STEP;
    dy      = xi >>> STEP;
    vec_nxt = vec_i;
    if (!yi[VEC_W-1]) begin
      vec_nxt.x   = xi + dx;
      vec_nxt.y   = yi - dy;
      vec_nxt.ang = vec_i.ang + atan_step(STEP);
    end else begin
      vec_nxt.x   = xi - dx;
      vec_nxt.y   = yi + dy;
      vec_nxt.ang = vec_i.ang - atan_step(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_o = vec_r;

endmodule

[rtl/eul_cordic_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_cordic_chain
// Two-argument arctangent: half-plane fold stage, then a row of rotation
// cells; the angle leaves rounded to Q4.13, unclamped.
// ----------------------------------------------------------------------------
module eul_cordic_chain
  import eul_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ARG_W-1:0] arg_y,
  input  logic signed [ARG_W-1:0] arg_x,
  output logic signed [RND_W-1:0] angle,
  output logic                    zero
);

  logic signed [VEC_W-1:0] ex;
  logic signed [VEC_W-1:0] ey;
  logic signed [ANG_W-1:0] ang_rnd;
  logic signed [ANG_W-1:0] ang_sh;
  eul_vec_t                fold_nxt;
  eul_vec_t                stage [CORDIC_STEPS+1];

  always_comb begin
    ex            = VEC_W'(arg_x);
    ey            = VEC_W'(arg_y);
    fold_nxt.zero = (arg_x == '0) && (arg_y == '0);
    if (arg_x[ARG_W-1]) begin
      fold_nxt.x   = -ex;
      fold_nxt.y   = -ey;
      fold_nxt.ang = arg_y[ARG_W-1] ? -PI_WIDE : PI_WIDE;
    end else begin
      fold_nxt.x   = ex;
      fold_nxt.y   = ey;
      fold_nxt.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage[0] <= fold_nxt;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    eul_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk  (clk),
      .en   (en),
      .vec_i(stage[k]),
      .vec_o(stage[k+1])
    );
  end

  always_comb begin
    ang_rnd = stage[CORDIC_STEPS].ang + RND_BIAS;
    ang_sh  = ang_rnd >>> RND_SHIFT;
    angle   = ang_sh[RND_W-1:0];
    zero    = stage[CORDIC_STEPS].zero;
  end

endmodule

[rtl/quaternion_to_euler_angles_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Z-Y-X roll, pitch and yaw from a unit quaternion, fully pipelined.
//
//   port       dir   beat contents
//   in_quat    sink  quat_w, quat_x, quat_y, quat_z   (Q1.15)
//   out_angle  src   roll, yaw (Q3.13), pitch (Q2.13), pitch_saturated
//
// One beat per cycle unless stalled; stages: products, sums, square,
// radicand, 31 square root cells, fold, 21 rotation cells, output register.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears only the stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit
  import eul_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  eul_quat_if.sink           in_quat,
  eul_angle_if.source        out_angle
);

  logic                     en;
  logic [PIPE_DEPTH-1:0]    vld_r;

  logic signed [PROD_W-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  eul_args_t                args_nxt;
  eul_args_t                args_r;
  logic [MAG_W-1:0]         mag_nxt;
  logic [MAG_W-1:0]         mag_r;
  logic [SQ_W-1:0]          sq_r;
  logic [SQ_W:0]            rad_full;
  eul_sqrt_t                sq_stage [SQRT_STEPS+1];
  eul_args_t                dly_r [DLY_LEN];
  eul_tag_t                 tag_r [TAG_LEN];

  logic signed [ARG_W-1:0]  cos_p;
  logic signed [RND_W-1:0]  roll_raw, pitch_raw, yaw_raw;
  logic                     roll_zero, pitch_zero, yaw_zero;
  logic signed [RND_W-1:0]  roll_c, pitch_c, yaw_c;

  logic signed [15:0]       roll_r;
  logic signed [14:0]       pitch_r;
  logic signed [15:0]       yaw_r;
  logic                     sat_r;

  assign en            = !vld_r[PIPE_DEPTH-1] || out_angle.ready;
  assign in_quat.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_quat.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_quat.quat_w * in_quat.quat_x;
      yz_r <= in_quat.quat_y * in_quat.quat_z;
      xx_r <= in_quat.quat_x * in_quat.quat_x;
      yy_r <= in_quat.quat_y * in_quat.quat_y;
      wz_r <= in_quat.quat_w * in_quat.quat_z;
      xy_r <= in_quat.quat_x * in_quat.quat_y;
      zz_r <= in_quat.quat_z * in_quat.quat_z;
      wy_r <= in_quat.quat_w * in_quat.quat_y;
      zx_r <= in_quat.quat_z * in_quat.quat_x;
    end
  end

  always_comb begin
    args_nxt.roll_a = (ARG_W'(wx_r) + ARG_W'(yz_r)) <<< 1;
    args_nxt.roll_b = ONE_Q30 - ((ARG_W'(xx_r) + ARG_W'(yy_r)) <<< 1);
    args_nxt.yaw_a  = (ARG_W'(wz_r) + ARG_W'(xy_r)) <<< 1;
    args_nxt.yaw_b  = ONE_Q30 - ((ARG_W'(yy_r) + ARG_W'(zz_r)) <<< 1);
    args_nxt.sin_p  = (ARG_W'(wy_r) - ARG_W'(zx_r)) <<< 1;
    args_nxt.sat    = (args_nxt.sin_p >= ONE_Q30) || (args_nxt.sin_p <= -ONE_Q30);
    if (args_nxt.sin_p[ARG_W-1]) begin
      mag_nxt = MAG_W'(-args_nxt.sin_p);
    end else begin
      mag_nxt = MAG_W'(args_nxt.sin_p);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      args_r <= args_nxt;
      mag_r  <= mag_nxt;
      sq_r   <= mag_r * mag_r;
    end
  end

  assign rad_full = ((SQ_W+1)'(1) << SQ_W) - {1'b0, sq_r};

  always_ff @(posedge clk) begin
    if (en) begin
      sq_stage[0].rem  <= '0;
      sq_stage[0].root <= '0;
      sq_stage[0].rad  <= RAD_W'(rad_full);
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    eul_sqrt_cell u_sqrt (
      .clk (clk),
      .en  (en),
      .sq_i(sq_stage[k]),
      .sq_o(sq_stage[k+1])
    );
  end

  // hold the arctangent arguments beside the square root cells
  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= args_r;
      for (int k = 1; k < DLY_LEN; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
      tag_r[0].sat <= dly_r[DLY_LEN-1].sat;
      tag_r[0].neg <= dly_r[DLY_LEN-1].sin_p[ARG_W-1];
      for (int k = 1; k < TAG_LEN; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign cos_p = $signed({{(ARG_W-ROOT_W){1'b0}}, sq_stage[SQRT_STEPS].root});

  eul_cordic_chain u_roll (
    .clk  (clk),
    .en   (en),
    .arg_y(dly_r[DLY_LEN-1].roll_a),
    .arg_x(dly_r[DLY_LEN-1].roll_b),
    .angle(roll_raw),
    .zero (roll_zero)
  );

  eul_cordic_chain u_pitch (
    .clk  (clk),
    .en   (en),
    .arg_y(dly_r[DLY_LEN-1].sin_p),
    .arg_x(cos_p),
    .angle(pitch_raw),
    .zero (pitch_zero)
  );

  eul_cordic_chain u_yaw (
    .clk  (clk),
    .en   (en),
    .arg_y(dly_r[DLY_LEN-1].yaw_a),
    .arg_x(dly_r[DLY_LEN-1].yaw_b),
    .angle(yaw_raw),
    .zero (yaw_zero)
  );

  always_comb begin
    roll_c = roll_zero ? '0 : clamp_ang(roll_raw, PI_Q13);
    yaw_c  = yaw_zero ? '0 : clamp_ang(yaw_raw, PI_Q13);
    if (tag_r[TAG_LEN-1].sat) begin
      pitch_c = tag_r[TAG_LEN-1].neg ? -HALF_PI_Q13 : HALF_PI_Q13;
    end else if (pitch_zero) begin
      pitch_c = '0;
    end else begin
      pitch_c = clamp_ang(pitch_raw, HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_c[15:0];
      pitch_r <= pitch_c[14:0];
      yaw_r   <= yaw_c[15:0];
      sat_r   <= tag_r[TAG_LEN-1].sat;
    end
  end

  assign out_angle.valid           = vld_r[PIPE_DEPTH-1];
  assign out_angle.roll_angle      = roll_r;
  assign out_angle.pitch_angle     = pitch_r;
  assign out_angle.yaw_angle       = yaw_r;
  assign out_angle.pitch_saturated = sat_r;

  a_sat_pitch : assert property (@(posedge clk) disable iff (!rst_n)
    (out_angle.valid && out_angle.pitch_saturated) |->
      (out_angle.pitch_angle == 15'sd12868 || out_angle.pitch_angle == -15'sd12868))
    else $error("saturated pitch beat is not at a right angle");

  a_roll_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_angle.valid |->
      (out_angle.roll_angle <= 16'sd25736 && out_angle.roll_angle >= -16'sd25736))
    else $error("roll beat outside half turn");

  a_yaw_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_angle.valid |->
      (out_angle.yaw_angle <= 16'sd25736 && out_angle.yaw_angle >= -16'sd25736))
    else $error("yaw beat outside half turn");

  a_adv : assert property (@(posedge clk) disable iff (!rst_n)
    (in_quat.valid && in_quat.ready) |=> vld_r[0])
    else $error("accepted quaternion beat lost at entry");

endmodule
